[design/pidso_pkg.sv]
// ----------------------------------------------------------------------------
// pidso_pkg: shared types and constants for the shaped-output PID block
// Value formats, register indexes, mode bits, sequencer states, divider ports.
// ----------------------------------------------------------------------------
package pidso_pkg;

  localparam int VALUE_W    = 32;  // Q16.16 values
  localparam int FRAC_BITS  = 16;
  localparam int STEP_W     = 25;  // time step, 2^-24 s units
  localparam int TIME_FRAC  = 24;
  localparam int ALPHA_FRAC = 30;
  localparam int STEP_MIN   = 17;
  localparam int CFG_W      = 64;
  localparam int NUM_REGS   = 8;
  localparam int IDX_W      = 3;
  localparam int SAT_IN_W   = 68;

  // shared divider sizing
  localparam int DIV_DVD_W = 57;
  localparam int DIV_DVS_W = 41;
  localparam int DIV_QUO_W = 31;
  localparam int DIV_CNT_W = 5;

  // register indexes
  localparam int REG_GAINS_PI  = 0;
  localparam int REG_GAINS_DFF = 1;
  localparam int REG_OUT_LIM   = 2;
  localparam int REG_INT_LIM   = 3;
  localparam int REG_TGT_LIM   = 4;
  localparam int REG_SEP_TH    = 5;
  localparam int REG_SHAPER    = 6;
  localparam int REG_MODES     = 7;

  // mode bits
  localparam int MODE_TGTLIM = 0;
  localparam int MODE_SEP    = 1;
  localparam int MODE_DONTGT = 2;
  localparam int MODE_DBAND  = 3;
  localparam int MODE_FILT   = 4;
  localparam int MODE_SLEW   = 5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK,
    ST_P,
    ST_FF,
    ST_INC,
    ST_COEF,
    ST_COEF_W,
    ST_SCALE_M,
    ST_SCALE,
    ST_RATE,
    ST_RATE_W,
    ST_D_M,
    ST_D,
    ST_CAND,
    ST_IT_M,
    ST_IT,
    ST_SHAPE,
    ST_ALPHA_W,
    ST_FILT_M,
    ST_FILT,
    ST_SLEW_M,
    ST_SLEW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] cnt;    // quotient bits to produce
    logic [DIV_DVD_W-1:0] dvd;
    logic [DIV_DVS_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

  // saturate a wide signed value to the value range
  function automatic logic signed [VALUE_W-1:0] sat(input logic signed [SAT_IN_W-1:0] x);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    logic signed [VALUE_W-1:0]  r;
    hi = SAT_IN_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}}));
    lo = SAT_IN_W'(signed'({1'b1, {(VALUE_W-1){1'b0}}}));
    if (x > hi) begin
      r = hi[VALUE_W-1:0];
    end else if (x < lo) begin
      r = lo[VALUE_W-1:0];
    end else begin
      r = x[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/pidso_div.sv]
// ----------------------------------------------------------------------------
// pidso_div: shared restoring divider, one quotient bit per cycle
// Caller guarantees the quotient fits in req.cnt bits.
// ----------------------------------------------------------------------------
module pidso_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidso_pkg::div_req_t req_i,
  output pidso_pkg::div_rsp_t rsp_o
);

  localparam int DVD_W = pidso_pkg::DIV_DVD_W;
  localparam int DVS_W = pidso_pkg::DIV_DVS_W;
  localparam int QUO_W = pidso_pkg::DIV_QUO_W;
  localparam int CNT_W = pidso_pkg::DIV_CNT_W;
  localparam int SH_W  = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [SH_W-1:0]  lsh;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign lsh   = SH_W'(DVD_W) - SH_W'(req_i.cnt);

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = DVS_W'(req_i.dvd >> req_i.cnt);
      dvd_d  = req_i.dvd << lsh;
      dvs_d  = req_i.dvs;
      quo_d  = '0;
      cnt_d  = req_i.cnt;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_d = dvd_q << 1;
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[design/pid_controller_shaped_output_top.sv]
// ----------------------------------------------------------------------------
// pid_controller_shaped_output_top: Q16.16 PID step with output shaping
// A load beat goes straight to the result state; a deadband step ends after
//   the check state; separation fade, unsaturated derivative rate and filter
//   each wait on the shared divider, and the filter adds its multiply and
//   update states.
// Throughput: one beat at a time; next input taken the cycle after the result is taken.
// Reset: async active low; configuration registers and all controller state clear to zero.
// ----------------------------------------------------------------------------
module pid_controller_shaped_output_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [pidso_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [pidso_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input beats
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic signed [pidso_pkg::VALUE_W-1:0] measured_i,
  input  logic signed [pidso_pkg::VALUE_W-1:0] setpoint_i,
  input  logic [pidso_pkg::STEP_W-1:0]         time_step_i,
  input  logic signed [pidso_pkg::VALUE_W-1:0] shaper_load_value_i,
  // result beats
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pidso_pkg::VALUE_W-1:0] drive_o,
  output logic signed [pidso_pkg::VALUE_W-1:0] p_term_o,
  output logic signed [pidso_pkg::VALUE_W-1:0] i_term_o,
  output logic signed [pidso_pkg::VALUE_W-1:0] d_term_o,
  output logic signed [pidso_pkg::VALUE_W-1:0] ff_term_o,
  output logic                                 in_deadband_o
);

  localparam int VW = pidso_pkg::VALUE_W;
  localparam int FB = pidso_pkg::FRAC_BITS;
  localparam int SW = pidso_pkg::STEP_W;
  localparam int TF = pidso_pkg::TIME_FRAC;
  localparam int AF = pidso_pkg::ALPHA_FRAC;
  localparam int XW = pidso_pkg::SAT_IN_W;
  localparam int CW = pidso_pkg::CFG_W;
  localparam int DVD_W = pidso_pkg::DIV_DVD_W;
  localparam int DVS_W = pidso_pkg::DIV_DVS_W;
  localparam int CNT_W = pidso_pkg::DIV_CNT_W;
  localparam int MW = VW + 1;        // multiplier operand
  localparam int PW = 2 * MW;        // product
  localparam int WW = VW + 4;        // wide shaping arithmetic

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] cfg_q [pidso_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pidso_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  logic signed [VW-1:0] kp, ki, kd, kff, omax, omin, imax, imin, tmax, tmin;
  logic signed [VW-1:0] tha, thb, dband;
  logic [VW-1:0]        slew, tau;
  logic [5:0]           modes;

  assign kp    = signed'(cfg_q[pidso_pkg::REG_GAINS_PI][32 +: VW]);
  assign ki    = signed'(cfg_q[pidso_pkg::REG_GAINS_PI][0 +: VW]);
  assign kd    = signed'(cfg_q[pidso_pkg::REG_GAINS_DFF][32 +: VW]);
  assign kff   = signed'(cfg_q[pidso_pkg::REG_GAINS_DFF][0 +: VW]);
  assign omax  = signed'(cfg_q[pidso_pkg::REG_OUT_LIM][32 +: VW]);
  assign omin  = signed'(cfg_q[pidso_pkg::REG_OUT_LIM][0 +: VW]);
  assign imax  = signed'(cfg_q[pidso_pkg::REG_INT_LIM][32 +: VW]);
  assign imin  = signed'(cfg_q[pidso_pkg::REG_INT_LIM][0 +: VW]);
  assign tmax  = signed'(cfg_q[pidso_pkg::REG_TGT_LIM][32 +: VW]);
  assign tmin  = signed'(cfg_q[pidso_pkg::REG_TGT_LIM][0 +: VW]);
  assign tha   = signed'(cfg_q[pidso_pkg::REG_SEP_TH][32 +: VW]);
  assign thb   = signed'(cfg_q[pidso_pkg::REG_SEP_TH][0 +: VW]);
  assign slew  = cfg_q[pidso_pkg::REG_SHAPER][32 +: VW];
  assign tau   = cfg_q[pidso_pkg::REG_SHAPER][0 +: VW];
  assign dband = signed'(cfg_q[pidso_pkg::REG_MODES][32 +: VW]);
  assign modes = cfg_q[pidso_pkg::REG_MODES][5:0];

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  pidso_pkg::state_e state_q, state_d;

  // controller state kept between steps
  logic signed [VW-1:0] integ_q, integ_d;
  logic signed [VW-1:0] lerr_q, lerr_d;
  logic signed [VW-1:0] lsp_q, lsp_d;
  logic signed [VW-1:0] sv_q, sv_d;
  logic                 svv_q, svv_d;

  // per-step working registers
  logic [SW-1:0]        dt_q, dt_d;
  logic signed [VW-1:0] tgt_q, tgt_d;
  logic signed [VW-1:0] err_q, err_d;
  logic signed [VW:0]   aerr_q, aerr_d;
  logic signed [VW-1:0] p_q, p_d, ff_q, ff_d, d_q, d_d, it_q, it_d;
  logic signed [VW-1:0] inc0_q, inc0_d, cand_q, cand_d, rate_q, rate_d, lim_q, lim_d;
  logic [FB:0]          coef_q, coef_d;
  logic [AF-1:0]        alpha_q, alpha_d;
  logic signed [VW+1:0] shaped_q, shaped_d;

  // result register
  logic signed [VW-1:0] drive_q, drive_d, po_q, po_d, io_q, io_d;
  logic signed [VW-1:0] do_q, do_d, fo_q, fo_d;
  logic                 indb_q, indb_d;

  // shared multiplier, registered product
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_q;

  // shared divider
  pidso_pkg::div_req_t div_req;
  pidso_pkg::div_rsp_t div_rsp;

  pidso_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Front end: step clamp, setpoint clamp, error
  // --------------------------------------------------------------------------
  logic [SW-1:0]        dt_in;
  logic signed [VW-1:0] tgt_in, err_in;
  logic signed [VW:0]   err_wide;

  always_comb begin
    dt_in = (time_step_i < SW'(pidso_pkg::STEP_MIN)) ? SW'(pidso_pkg::STEP_MIN)
                                                     : time_step_i;
    tgt_in = setpoint_i;
    if (modes[pidso_pkg::MODE_TGTLIM]) begin
      if (setpoint_i < tmin) begin
        tgt_in = tmin;
      end else if (setpoint_i > tmax) begin
        tgt_in = tmax;
      end
    end
    err_wide = (VW+1)'(tgt_in) - (VW+1)'(measured_i);
    err_in   = pidso_pkg::sat(XW'(err_wide));
  end

  // --------------------------------------------------------------------------
  // Decisions shared by sequencer and datapath
  // --------------------------------------------------------------------------
  logic                 db_hit, coef_div, rate_sat, filt_on, slew_on, shape_on;
  logic signed [VW:0]   tha_e, thb_e, coef_num;
  logic signed [VW+1:0] coef_den;
  logic signed [VW+1:0] rdiff;
  logic [VW+1:0]        rmag;

  always_comb begin
    db_hit = modes[pidso_pkg::MODE_DBAND] && (aerr_q <= (VW+1)'(dband));

    // separation thresholds, inverted or equal pair folds to B + 1 LSB
    thb_e = (VW+1)'(thb);
    tha_e = (tha <= thb) ? thb_e + (VW+1)'(1) : (VW+1)'(tha);
    coef_div = modes[pidso_pkg::MODE_SEP] && (aerr_q < tha_e) && (aerr_q > thb_e);
    coef_num = tha_e - aerr_q;
    coef_den = (VW+2)'(tha_e) - (VW+2)'(thb_e);

    // derivative difference on error or on setpoint
    if (modes[pidso_pkg::MODE_DONTGT]) begin
      rdiff = (VW+2)'(lsp_q) - (VW+2)'(tgt_q);
    end else begin
      rdiff = (VW+2)'(err_q) - (VW+2)'(lerr_q);
    end
    rmag     = (rdiff < 0) ? unsigned'(-rdiff) : unsigned'(rdiff);
    // quotient reaches 2^31 exactly when |diff| >= dt * 2^7
    rate_sat = rmag >= ((VW+2)'(dt_q) << (VW - 1 - TF));

    shape_on = modes[pidso_pkg::MODE_FILT] || modes[pidso_pkg::MODE_SLEW];
    filt_on  = modes[pidso_pkg::MODE_FILT] && (tau != '0);
    slew_on  = modes[pidso_pkg::MODE_SLEW] && (slew != '0);
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidso_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = command_i ? pidso_pkg::ST_OUT : pidso_pkg::ST_CHK;
        end
      end
      pidso_pkg::ST_CHK:     state_d = db_hit ? pidso_pkg::ST_OUT : pidso_pkg::ST_P;
      pidso_pkg::ST_P:       state_d = pidso_pkg::ST_FF;
      pidso_pkg::ST_FF:      state_d = pidso_pkg::ST_INC;
      pidso_pkg::ST_INC:     state_d = pidso_pkg::ST_COEF;
      pidso_pkg::ST_COEF:    state_d = coef_div ? pidso_pkg::ST_COEF_W : pidso_pkg::ST_SCALE_M;
      pidso_pkg::ST_COEF_W: begin
        if (div_rsp.done) begin
          state_d = pidso_pkg::ST_SCALE_M;
        end
      end
      pidso_pkg::ST_SCALE_M: state_d = pidso_pkg::ST_SCALE;
      pidso_pkg::ST_SCALE:   state_d = pidso_pkg::ST_RATE;
      pidso_pkg::ST_RATE:    state_d = rate_sat ? pidso_pkg::ST_D_M : pidso_pkg::ST_RATE_W;
      pidso_pkg::ST_RATE_W: begin
        if (div_rsp.done) begin
          state_d = pidso_pkg::ST_D_M;
        end
      end
      pidso_pkg::ST_D_M:     state_d = pidso_pkg::ST_D;
      pidso_pkg::ST_D:       state_d = pidso_pkg::ST_CAND;
      pidso_pkg::ST_CAND:    state_d = pidso_pkg::ST_IT_M;
      pidso_pkg::ST_IT_M:    state_d = pidso_pkg::ST_IT;
      pidso_pkg::ST_IT:      state_d = pidso_pkg::ST_SHAPE;
      pidso_pkg::ST_SHAPE:   state_d = filt_on ? pidso_pkg::ST_ALPHA_W : pidso_pkg::ST_SLEW_M;
      pidso_pkg::ST_ALPHA_W: begin
        if (div_rsp.done) begin
          state_d = pidso_pkg::ST_FILT_M;
        end
      end
      pidso_pkg::ST_FILT_M:  state_d = pidso_pkg::ST_FILT;
      pidso_pkg::ST_FILT:    state_d = pidso_pkg::ST_SLEW_M;
      pidso_pkg::ST_SLEW_M:  state_d = pidso_pkg::ST_SLEW;
      pidso_pkg::ST_SLEW:    state_d = pidso_pkg::ST_OUT;
      pidso_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = pidso_pkg::ST_IDLE;
        end
      end
      default:               state_d = pidso_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Multiplier operand select; product lands one state later
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pidso_pkg::ST_CHK: begin
        mul_a = MW'(kp);
        mul_b = MW'(err_q);
      end
      pidso_pkg::ST_P: begin
        mul_a = MW'(kff);
        mul_b = MW'(tgt_q);
      end
      pidso_pkg::ST_FF: begin
        mul_a = MW'(err_q);
        mul_b = signed'(MW'(dt_q));
      end
      pidso_pkg::ST_SCALE_M: begin
        mul_a = MW'(inc0_q);
        mul_b = signed'(MW'(coef_q));
      end
      pidso_pkg::ST_D_M: begin
        mul_a = MW'(kd);
        mul_b = MW'(rate_q);
      end
      pidso_pkg::ST_D: begin
        mul_a = MW'(ki);
        mul_b = MW'(cand_q);
      end
      pidso_pkg::ST_IT_M: begin
        mul_a = MW'(ki);
        mul_b = MW'(integ_q);
      end
      pidso_pkg::ST_FILT_M: begin
        mul_a = MW'(lim_q) - MW'(sv_q);
        mul_b = signed'(MW'(alpha_q));
      end
      pidso_pkg::ST_SLEW_M: begin
        mul_a = signed'(MW'(slew));
        mul_b = signed'(MW'(dt_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Datapath updates per state
  // --------------------------------------------------------------------------
  logic signed [VW-1:0]  prod_q16, prod_q24, ic;
  logic signed [VW+2:0]  cand_sum;
  logic signed [VW+1:0]  usum, lsum;
  logic signed [WW-1:0]  dmax, delta, pre;
  logic signed [VW-1:0]  shaped_fin;

  assign prod_q16 = pidso_pkg::sat(XW'(prod_q >>> FB));
  assign prod_q24 = pidso_pkg::sat(XW'(prod_q >>> TF));
  assign ic       = prod_q16;

  always_comb begin
    integ_d  = integ_q;
    lerr_d   = lerr_q;
    lsp_d    = lsp_q;
    sv_d     = sv_q;
    svv_d    = svv_q;
    dt_d     = dt_q;
    tgt_d    = tgt_q;
    err_d    = err_q;
    aerr_d   = aerr_q;
    p_d      = p_q;
    ff_d     = ff_q;
    d_d      = d_q;
    it_d     = it_q;
    inc0_d   = inc0_q;
    cand_d   = cand_q;
    rate_d   = rate_q;
    lim_d    = lim_q;
    coef_d   = coef_q;
    alpha_d  = alpha_q;
    shaped_d = shaped_q;
    drive_d  = drive_q;
    po_d     = po_q;
    io_d     = io_q;
    do_d     = do_q;
    fo_d     = fo_q;
    indb_d   = indb_q;
    div_req  = '0;
    cand_sum = '0;
    usum     = '0;
    lsum     = '0;
    dmax     = '0;
    delta    = '0;
    pre      = '0;
    shaped_fin = '0;

    unique case (state_q)
      pidso_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i) begin
            // shaper preset beat
            sv_d    = shaper_load_value_i;
            svv_d   = 1'b1;
            drive_d = shaper_load_value_i;
            po_d    = '0;
            io_d    = '0;
            do_d    = '0;
            fo_d    = '0;
            indb_d  = 1'b0;
          end else begin
            dt_d   = dt_in;
            tgt_d  = tgt_in;
            err_d  = err_in;
            aerr_d = (err_in < 0) ? -(VW+1)'(err_in) : (VW+1)'(err_in);
          end
        end
      end
      pidso_pkg::ST_CHK: begin
        if (db_hit) begin
          sv_d    = '0;
          svv_d   = 1'b1;
          lerr_d  = err_q;
          lsp_d   = tgt_q;
          drive_d = '0;
          po_d    = '0;
          io_d    = '0;
          do_d    = '0;
          fo_d    = '0;
          indb_d  = 1'b1;
        end
      end
      pidso_pkg::ST_P:   p_d    = prod_q16;
      pidso_pkg::ST_FF:  ff_d   = prod_q16;
      pidso_pkg::ST_INC: inc0_d = prod_q24;
      pidso_pkg::ST_COEF: begin
        if (coef_div) begin
          div_req.start = 1'b1;
          div_req.cnt   = CNT_W'(FB);
          div_req.dvd   = DVD_W'(unsigned'(coef_num)) << FB;
          div_req.dvs   = DVS_W'(unsigned'(coef_den));
        end else if (modes[pidso_pkg::MODE_SEP] && (aerr_q >= tha_e)) begin
          coef_d = '0;
        end else begin
          coef_d = (FB+1)'(1) << FB;
        end
      end
      pidso_pkg::ST_COEF_W: begin
        if (div_rsp.done) begin
          coef_d = (FB+1)'(div_rsp.quo);
        end
      end
      pidso_pkg::ST_SCALE: begin
        // integral candidate, clamped then saturated
        cand_sum = (VW+3)'(integ_q) + (VW+3)'(prod_q >>> FB);
        if (cand_sum < (VW+3)'(imin)) begin
          cand_d = imin;
        end else if (cand_sum > (VW+3)'(imax)) begin
          cand_d = imax;
        end else begin
          cand_d = pidso_pkg::sat(XW'(cand_sum));
        end
      end
      pidso_pkg::ST_RATE: begin
        if (rate_sat) begin
          rate_d = (rdiff > 0) ? signed'({1'b0, {(VW-1){1'b1}}})
                               : signed'({1'b1, {(VW-1){1'b0}}});
        end else begin
          div_req.start = 1'b1;
          div_req.cnt   = CNT_W'(VW - 1);
          div_req.dvd   = DVD_W'(rmag) << TF;
          div_req.dvs   = DVS_W'(dt_q);
        end
      end
      pidso_pkg::ST_RATE_W: begin
        if (div_rsp.done) begin
          rate_d = (rdiff < 0) ? -VW'(signed'({1'b0, div_rsp.quo}))
                               : VW'(signed'({1'b0, div_rsp.quo}));
        end
      end
      pidso_pkg::ST_D: d_d = prod_q16;
      pidso_pkg::ST_CAND: begin
        // freeze the integral when the output saturates along the error
        usum = (VW+2)'(p_q) + (VW+2)'(ic) + (VW+2)'(d_q) + (VW+2)'(ff_q);
        if (!(((usum > (VW+2)'(omax)) && (err_q > 0)) ||
              ((usum < (VW+2)'(omin)) && (err_q < 0)))) begin
          integ_d = cand_q;
        end
      end
      pidso_pkg::ST_IT: begin
        it_d = prod_q16;
        lsum = (VW+2)'(p_q) + (VW+2)'(prod_q16) + (VW+2)'(d_q) + (VW+2)'(ff_q);
        if (lsum < (VW+2)'(omin)) begin
          lim_d = omin;
        end else if (lsum > (VW+2)'(omax)) begin
          lim_d = omax;
        end else begin
          lim_d = pidso_pkg::sat(XW'(lsum));
        end
        if (shape_on && !svv_q) begin
          sv_d  = lim_d;
          svv_d = 1'b1;
        end
      end
      pidso_pkg::ST_SHAPE: begin
        if (filt_on) begin
          // alpha = dt / (tau + dt) in Q30, tau rescaled to time units
          div_req.start = 1'b1;
          div_req.cnt   = CNT_W'(AF);
          div_req.dvd   = DVD_W'(dt_q) << AF;
          div_req.dvs   = (DVS_W'(tau) << (TF - FB)) + DVS_W'(dt_q);
        end else begin
          shaped_d = (VW+2)'(lim_q);
        end
      end
      pidso_pkg::ST_ALPHA_W: begin
        if (div_rsp.done) begin
          alpha_d = AF'(div_rsp.quo);
        end
      end
      pidso_pkg::ST_FILT: begin
        shaped_d = (VW+2)'(sv_q) + (VW+2)'(prod_q >>> AF);
      end
      pidso_pkg::ST_SLEW: begin
        pre = WW'(shaped_q);
        if (slew_on) begin
          dmax  = WW'(prod_q >>> TF);
          delta = WW'(shaped_q) - WW'(sv_q);
          if (delta > dmax) begin
            delta = dmax;
          end else if (delta < -dmax) begin
            delta = -dmax;
          end
          pre = WW'(sv_q) + delta;
        end
        if (shape_on) begin
          if (pre < WW'(omin)) begin
            shaped_fin = omin;
          end else if (pre > WW'(omax)) begin
            shaped_fin = omax;
          end else begin
            shaped_fin = pidso_pkg::sat(XW'(pre));
          end
        end else begin
          shaped_fin = lim_q;
        end
        sv_d    = shaped_fin;
        svv_d   = 1'b1;
        lerr_d  = err_q;
        lsp_d   = tgt_q;
        drive_d = shaped_fin;
        po_d    = p_q;
        io_d    = it_q;
        do_d    = d_q;
        fo_d    = ff_q;
        indb_d  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidso_pkg::ST_IDLE;
      integ_q <= '0;
      lerr_q  <= '0;
      lsp_q   <= '0;
      sv_q    <= '0;
      svv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      integ_q <= integ_d;
      lerr_q  <= lerr_d;
      lsp_q   <= lsp_d;
      sv_q    <= sv_d;
      svv_q   <= svv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    tgt_q    <= tgt_d;
    err_q    <= err_d;
    aerr_q   <= aerr_d;
    p_q      <= p_d;
    ff_q     <= ff_d;
    d_q      <= d_d;
    it_q     <= it_d;
    inc0_q   <= inc0_d;
    cand_q   <= cand_d;
    rate_q   <= rate_d;
    lim_q    <= lim_d;
    coef_q   <= coef_d;
    alpha_q  <= alpha_d;
    shaped_q <= shaped_d;
    drive_q  <= drive_d;
    po_q     <= po_d;
    io_q     <= io_d;
    do_q     <= do_d;
    fo_q     <= fo_d;
    indb_q   <= indb_d;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_ready_o    = (state_q == pidso_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == pidso_pkg::ST_OUT);
  assign drive_o       = drive_q;
  assign p_term_o      = po_q;
  assign i_term_o      = io_q;
  assign d_term_o      = do_q;
  assign ff_term_o     = fo_q;
  assign in_deadband_o = indb_q;

endmodule

[sim/pid_controller_shaped_output_top_tb.sv]
// ----------------------------------------------------------------------------
// pid_controller_shaped_output_top_tb: self-checking bench for the PID block
// A directed table, then random control steps and shaper loads, all checked
// beat by beat against an in-bench model or a typed drive. Configuration is
// rewritten between phases while the block is idle. Both channels idle at
// random rates and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module pid_controller_shaped_output_top_tb;

  typedef struct packed {
    logic [31:0] drive;
    logic [31:0] p_term;
    logic [31:0] i_term;
    logic [31:0] d_term;
    logic [31:0] ff_term;
    logic        in_deadband;
  } pid_res_t;

  // directed row: the typed value is only the drive, every other field is zero
  typedef struct packed {
    logic        cmd;
    logic [31:0] meas;
    logic [31:0] sp;
    logic [24:0] dt;
    logic [31:0] load;
    logic        typed;
    logic [31:0] exp_drive;
  } dir_row_t;

  localparam int NUM_ROWS   = 22;
  localparam int RAND_ITEMS = 1440;
  localparam int BLOCK_LEN  = 90;   // random beats per configuration

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pidso_pkg::IDX_W-1:0]   cfg_idx_i;
  logic [pidso_pkg::CFG_W-1:0]   cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          command_i;
  logic [pidso_pkg::VALUE_W-1:0] measured_i;
  logic [pidso_pkg::VALUE_W-1:0] setpoint_i;
  logic [pidso_pkg::STEP_W-1:0]  time_step_i;
  logic [pidso_pkg::VALUE_W-1:0] shaper_load_value_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [pidso_pkg::VALUE_W-1:0] drive_o;
  logic [pidso_pkg::VALUE_W-1:0] p_term_o;
  logic [pidso_pkg::VALUE_W-1:0] i_term_o;
  logic [pidso_pkg::VALUE_W-1:0] d_term_o;
  logic [pidso_pkg::VALUE_W-1:0] ff_term_o;
  logic                          in_deadband_o;

  pid_controller_shaped_output_top dut (.*);

  // controller model state and register copy
  logic [63:0] mdl_regs [pidso_pkg::NUM_REGS];
  longint      integ_acc;
  longint      prev_err;
  longint      prev_tgt;
  longint      shp_val;
  bit          shp_ok;

  pid_res_t    pending_res [$];
  int          err_cnt;
  int          snd_idle;    // percent of cycles the input side idles
  int          rcv_idle;    // percent of cycles the result side stalls
  logic        hold_req;    // asks the result side for one long hold-off
  bit          hold_done;
  dir_row_t    dir_tab [NUM_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clampv(longint x, longint mn, longint mx);
    if (x < mn) return mn;
    if (x > mx) return mx;
    return x;
  endfunction

  // one beat through the controller; updates the model state
  function automatic pid_res_t pid_predict(logic cmd, logic [31:0] meas_in,
                                           logic [31:0] sp_in, logic [24:0] dt_in,
                                           logic [31:0] load_in);
    pid_res_t r;
    logic [63:0] modes;
    longint kp, ki, kd, kff, omax, omin, imax, imin, tmax, tmin, tha, thb;
    longint slew, tau, dband, dt, meas, tgt, err, aerr, p, d, ff, it;
    longint coef, inc, cand, usum, lim, shaped, diff, rate, alpha, dmax, delta;
    r = '0;
    modes = mdl_regs[pidso_pkg::REG_MODES];
    kp   = sx32(mdl_regs[pidso_pkg::REG_GAINS_PI][63:32]);
    ki   = sx32(mdl_regs[pidso_pkg::REG_GAINS_PI][31:0]);
    kd   = sx32(mdl_regs[pidso_pkg::REG_GAINS_DFF][63:32]);
    kff  = sx32(mdl_regs[pidso_pkg::REG_GAINS_DFF][31:0]);
    omax = sx32(mdl_regs[pidso_pkg::REG_OUT_LIM][63:32]);
    omin = sx32(mdl_regs[pidso_pkg::REG_OUT_LIM][31:0]);
    imax = sx32(mdl_regs[pidso_pkg::REG_INT_LIM][63:32]);
    imin = sx32(mdl_regs[pidso_pkg::REG_INT_LIM][31:0]);
    tmax = sx32(mdl_regs[pidso_pkg::REG_TGT_LIM][63:32]);
    tmin = sx32(mdl_regs[pidso_pkg::REG_TGT_LIM][31:0]);
    tha  = sx32(mdl_regs[pidso_pkg::REG_SEP_TH][63:32]);
    thb  = sx32(mdl_regs[pidso_pkg::REG_SEP_TH][31:0]);
    slew = longint'({32'b0, mdl_regs[pidso_pkg::REG_SHAPER][63:32]});
    tau  = longint'({32'b0, mdl_regs[pidso_pkg::REG_SHAPER][31:0]});
    dband = sx32(modes[63:32]);

    if (cmd) begin
      shp_val = sx32(load_in);
      shp_ok  = 1'b1;
      r.drive = load_in;
      return r;
    end

    dt = longint'({39'b0, dt_in});
    if (dt < pidso_pkg::STEP_MIN) dt = pidso_pkg::STEP_MIN;
    meas = sx32(meas_in);
    tgt  = sx32(sp_in);
    if (modes[pidso_pkg::MODE_TGTLIM]) tgt = clampv(tgt, tmin, tmax);
    err  = clip32(tgt - meas);
    aerr = (err < 0) ? -err : err;

    // inside the deadband: all zero, shaper cleared, integral kept
    if (modes[pidso_pkg::MODE_DBAND] && aerr <= dband) begin
      shp_val  = 0;
      shp_ok   = 1'b1;
      prev_err = err;
      prev_tgt = tgt;
      r.in_deadband = 1'b1;
      return r;
    end

    p = clip32((kp * err) >>> pidso_pkg::FRAC_BITS);

    coef = 64'sd1 <<< pidso_pkg::FRAC_BITS;
    if (modes[pidso_pkg::MODE_SEP]) begin
      if (tha <= thb) tha = thb + 1;
      if (aerr >= tha) coef = 0;
      else if (aerr > thb) coef = ((tha - aerr) <<< pidso_pkg::FRAC_BITS) / (tha - thb);
    end

    diff = modes[pidso_pkg::MODE_DONTGT] ? -(tgt - prev_tgt) : (err - prev_err);
    rate = clip32((diff * (64'sd1 <<< pidso_pkg::TIME_FRAC)) / dt);
    d    = clip32((kd * rate) >>> pidso_pkg::FRAC_BITS);
    ff   = clip32((kff * tgt) >>> pidso_pkg::FRAC_BITS);

    inc  = clip32((err * dt) >>> pidso_pkg::TIME_FRAC);
    inc  = (inc * coef) >>> pidso_pkg::FRAC_BITS;
    cand = clip32(clampv(integ_acc + inc, imin, imax));

    // anti-windup: freeze when saturating in the direction of the error
    usum = p + clip32((ki * cand) >>> pidso_pkg::FRAC_BITS) + d + ff;
    if (!((usum > omax && err > 0) || (usum < omin && err < 0))) integ_acc = cand;

    it  = clip32((ki * integ_acc) >>> pidso_pkg::FRAC_BITS);
    lim = clip32(clampv(p + it + d + ff, omin, omax));

    if (modes[pidso_pkg::MODE_FILT] || modes[pidso_pkg::MODE_SLEW]) begin
      if (!shp_ok) begin
        shp_val = lim;
        shp_ok  = 1'b1;
      end
      shaped = lim;
      if (modes[pidso_pkg::MODE_FILT] && tau != 0) begin
        alpha  = (dt <<< pidso_pkg::ALPHA_FRAC) /
                 ((tau <<< (pidso_pkg::TIME_FRAC - pidso_pkg::FRAC_BITS)) + dt);
        shaped = shp_val + (((lim - shp_val) * alpha) >>> pidso_pkg::ALPHA_FRAC);
      end
      if (modes[pidso_pkg::MODE_SLEW] && slew != 0) begin
        dmax  = (slew * dt) >>> pidso_pkg::TIME_FRAC;
        delta = shaped - shp_val;
        if (delta > dmax) delta = dmax;
        else if (delta < -dmax) delta = -dmax;
        shaped = shp_val + delta;
      end
      shaped = clip32(clampv(shaped, omin, omax));
    end else begin
      shaped = lim;
      shp_ok = 1'b1;
    end
    shp_val  = shaped;
    prev_err = err;
    prev_tgt = tgt;

    r.drive   = shaped[31:0];
    r.p_term  = p[31:0];
    r.i_term  = it[31:0];
    r.d_term  = d[31:0];
    r.ff_term = ff[31:0];
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3, 4, 5: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly an ordered min/max pair, sometimes anything
  function automatic logic [63:0] rand_limits();
    if ($urandom_range(9) < 7)
      return {32'($urandom_range(0, 32'h0400_0000)), -32'($urandom_range(0, 32'h0400_0000))};
    return {rand_word(), rand_word()};
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      4:          return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [24:0] rand_step();
    case ($urandom_range(9))
      0, 1, 2:       return 25'($urandom_range(0, 40));
      3, 4, 5, 6, 7: return 25'($urandom_range(1000, 200000));
      8:             return 25'h100_0000;
      default:       return 25'($urandom_range(0, 25'h100_0000));
    endcase
  endfunction

  task automatic write_reg(int idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= pidso_pkg::IDX_W'(idx);
    cfg_wdata_i <= val;
    mdl_regs[idx] = val;
    @(posedge clk_i);
  endtask

  // drop valid, wait for every result, then rewrite all registers
  task automatic load_config(logic [63:0] vals [pidso_pkg::NUM_REGS]);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int k = 0; k < pidso_pkg::NUM_REGS; k++) write_reg(k, vals[k]);
    cfg_we_i <= 1'b0;
  endtask

  task automatic rand_config(int flavor);
    logic [63:0] v [pidso_pkg::NUM_REGS];
    case (flavor)
      0: for (int k = 0; k < pidso_pkg::NUM_REGS; k++) v[k] = '1;
      1: for (int k = 0; k < pidso_pkg::NUM_REGS; k++) v[k] = {32'h7fff_ffff, 32'h8000_0000};
      2: for (int k = 0; k < pidso_pkg::NUM_REGS; k++) v[k] = '0;
      default: begin
        v[pidso_pkg::REG_GAINS_PI]  = {rand_word(), rand_word()};
        v[pidso_pkg::REG_GAINS_DFF] = {rand_word(), rand_word()};
        v[pidso_pkg::REG_OUT_LIM]   = rand_limits();
        v[pidso_pkg::REG_INT_LIM]   = rand_limits();
        v[pidso_pkg::REG_TGT_LIM]   = rand_limits();
        v[pidso_pkg::REG_SEP_TH]    = rand_limits();
        v[pidso_pkg::REG_SHAPER]    = {32'($urandom_range(0, 32'h0100_0000)),
                                       32'($urandom_range(0, 32'h0001_0000))};
        if ($urandom_range(5) == 0) v[pidso_pkg::REG_SHAPER] = {$urandom, $urandom};
        v[pidso_pkg::REG_MODES]     = {$urandom_range(1) ? 32'($urandom_range(0, 32'h0002_0000))
                                                         : $urandom, $urandom};
        if ($urandom_range(4) == 0) v[pidso_pkg::REG_MODES][5:0] = 6'h3f;
      end
    endcase
    load_config(v);
  endtask

  // drive one beat and hold it until accepted; predict at acceptance
  task automatic send_beat(logic cmd, logic [31:0] meas, logic [31:0] sp,
                           logic [24:0] dt, logic [31:0] load,
                           bit typed, logic [31:0] exp_drive);
    pid_res_t exp_res;
    in_valid_i          <= 1'b1;
    command_i           <= cmd;
    measured_i          <= meas;
    setpoint_i          <= sp;
    time_step_i         <= dt;
    shaper_load_value_i <= load;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = pid_predict(cmd, meas, sp, dt, load);
    if (typed) begin
      exp_res = '0;
      exp_res.drive = exp_drive;
    end
    pending_res.push_back(exp_res);
  endtask

  // random gap after an accepted beat
  task automatic beat_gap();
    if ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
  endtask

  // directed rows; rows 0..3 run with reset registers, so the drive is known
  initial begin
    dir_tab[0]  = '{1'b0, 32'h7fff_ffff, 32'h8000_0000, 25'd0, 32'h0, 1'b1, 32'h0};
    dir_tab[1]  = '{1'b1, 32'h0, 32'h0, 25'd0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff};
    dir_tab[2]  = '{1'b1, 32'h0, 32'h0, 25'd0, 32'h8000_0000, 1'b1, 32'h8000_0000};
    dir_tab[3]  = '{1'b0, 32'h0, 32'h0, 25'd1000000, 32'h0, 1'b1, 32'h0};
    // full-feature setup from here on
    dir_tab[4]  = '{1'b0, 32'h0, 32'h0010_0000, 25'd16, 32'h0, 1'b0, 32'h0};   // short step
    dir_tab[5]  = '{1'b0, 32'h0, 32'h0010_0000, 25'd17, 32'h0, 1'b0, 32'h0};
    dir_tab[6]  = '{1'b0, 32'h0, 32'h0010_0000, 25'h100_0000, 32'h0, 1'b0, 32'h0};
    dir_tab[7]  = '{1'b0, 32'h0, 32'h0000_4000, 25'd16384, 32'h0, 1'b0, 32'h0}; // deadband
    dir_tab[8]  = '{1'b0, 32'h0, 32'h0000_8000, 25'd16384, 32'h0, 1'b0, 32'h0}; // edge
    dir_tab[9]  = '{1'b0, 32'h0, 32'h0014_0000, 25'd16384, 32'h0, 1'b0, 32'h0}; // fade
    dir_tab[10] = '{1'b0, 32'h0, 32'h0040_0000, 25'd16384, 32'h0, 1'b0, 32'h0}; // beyond A
    dir_tab[11] = '{1'b0, 32'h0, 32'h0008_0000, 25'd16384, 32'h0, 1'b0, 32'h0}; // below B
    dir_tab[12] = '{1'b0, 32'h7fff_ffff, 32'h8000_0000, 25'd16384, 32'h0, 1'b0, 32'h0};
    dir_tab[13] = '{1'b0, 32'h8000_0000, 32'h7fff_ffff, 25'd16384, 32'h0, 1'b0, 32'h0};
    dir_tab[14] = '{1'b1, 32'hffff_ffff, 32'hffff_ffff, 25'h1ff_ffff, 32'h0005_0000,
                    1'b0, 32'h0};
    dir_tab[15] = '{1'b0, 32'h0, 32'h0020_0000, 25'd16384, 32'h0, 1'b0, 32'h0};
    dir_tab[16] = '{1'b0, 32'hffff_0000, 32'h0, 25'h100_0000, 32'h0, 1'b0, 32'h0};
    dir_tab[17] = '{1'b1, 32'h0, 32'h0, 25'd0, 32'h0, 1'b0, 32'h0};
    // derivative on setpoint, inverted thresholds
    dir_tab[18] = '{1'b0, 32'h0, 32'h0030_0000, 25'd65536, 32'h0, 1'b0, 32'h0};
    dir_tab[19] = '{1'b0, 32'h0, 32'hffd0_0000, 25'd65536, 32'h0, 1'b0, 32'h0};
    dir_tab[20] = '{1'b0, 32'h0, 32'h0000_0001, 25'd17, 32'h0, 1'b0, 32'h0};
    dir_tab[21] = '{1'b0, 32'h0010_0000, 32'h0010_0000, 25'd1, 32'h0, 1'b0, 32'h0};
  end

  // ------------------------------------------------------- input process
  initial begin
    logic [63:0] cfg_a [pidso_pkg::NUM_REGS];
    logic [63:0] cfg_b [pidso_pkg::NUM_REGS];
    int sent;
    cfg_a = '{{32'h0001_0000, 32'h0000_8000}, {32'h0000_0400, 32'h0000_4000},
              {32'h03e8_0000, 32'hfc18_0000}, {32'h0064_0000, 32'hff9c_0000},
              {32'h01f4_0000, 32'hfe0c_0000}, {32'h0032_0000, 32'h000a_0000},
              {32'h0064_0000, 32'h0000_028f}, {32'h0000_8000, 32'h0000_003f}};
    cfg_b = cfg_a;
    cfg_b[pidso_pkg::REG_SEP_TH] = {32'h0005_0000, 32'h0020_0000};
    cfg_b[pidso_pkg::REG_MODES]  = {32'h8000_0000, 32'h0000_0026};
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; command_i = 1'b0; measured_i = '0; setpoint_i = '0;
    time_step_i = '0; shaper_load_value_i = '0;
    hold_req = 1'b0;
    integ_acc = 0; prev_err = 0; prev_tgt = 0; shp_val = 0; shp_ok = 1'b0;
    for (int k = 0; k < pidso_pkg::NUM_REGS; k++) mdl_regs[k] = '0;
    err_cnt = 0;
    snd_idle = 24;
    rcv_idle = 88;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_ROWS; n++) begin
      if (n == 4) load_config(cfg_a);
      if (n == 18) load_config(cfg_b);
      send_beat(dir_tab[n].cmd, dir_tab[n].meas, dir_tab[n].sp, dir_tab[n].dt,
                dir_tab[n].load, dir_tab[n].typed, dir_tab[n].exp_drive);
      beat_gap();
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent % BLOCK_LEN == 0) begin
        rand_config(sent / BLOCK_LEN);
        // idling swaps at the first block past a third of the run and stops at the first block past two thirds
        if (sent >= RAND_ITEMS / 3 && sent < 2 * RAND_ITEMS / 3) begin
          snd_idle = 88; rcv_idle = 24;
        end else if (sent >= 2 * RAND_ITEMS / 3) begin
          snd_idle = 0; rcv_idle = 0;
          if (!hold_req) hold_req <= 1'b1;
        end
      end
      if ($urandom_range(19) == 0)
        send_beat(1'b1, $urandom, $urandom, 25'($urandom), rand_word(), 1'b0, 32'h0);
      else
        send_beat(1'b0, rand_value(), rand_value(), rand_step(), $urandom, 1'b0, 32'h0);
      sent++;
      beat_gap();
    end
    in_valid_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("pid_controller_shaped_output_top_tb: clean");
    end else begin
      $display("pid_controller_shaped_output_top_tb: errors");
    end
    $finish;
  end

  // ------------------------------------------------------ result process
  initial begin
    pid_res_t want;
    int hold_left;
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_res.size() == 0) begin
          $error("result beat with nothing expected: drive %h", drive_o);
          err_cnt++;
        end else begin
          want = pending_res.pop_front();
          if (drive_o !== want.drive) begin
            $error("drive: expected %h, got %h", want.drive, drive_o); err_cnt++;
          end
          if (p_term_o !== want.p_term) begin
            $error("p_term: expected %h, got %h", want.p_term, p_term_o); err_cnt++;
          end
          if (i_term_o !== want.i_term) begin
            $error("i_term: expected %h, got %h", want.i_term, i_term_o); err_cnt++;
          end
          if (d_term_o !== want.d_term) begin
            $error("d_term: expected %h, got %h", want.d_term, d_term_o); err_cnt++;
          end
          if (ff_term_o !== want.ff_term) begin
            $error("ff_term: expected %h, got %h", want.ff_term, ff_term_o); err_cnt++;
          end
          if (in_deadband_o !== want.in_deadband) begin
            $error("in_deadband: expected %b, got %b", want.in_deadband, in_deadband_o);
            err_cnt++;
          end
        end
      end
      // one long hold-off so the block fills and backs up the input side
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #30000000;
    $display("pid_controller_shaped_output_top_tb: errors");
    $finish;
  end

endmodule
